@@ rtl/core/rgb_hue_colour_classifier_defines.svh @@
// assertion macros shared by the colour classifier checker
`ifndef RGB_HUE_COLOUR_CLASSIFIER_DEFINES_SVH
`define RGB_HUE_COLOUR_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked on clk, off while in reset
`define RHCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colour classifier check failed");

// next-cycle implication, checked on clk, off while in reset
`define RHCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colour classifier check failed");

`endif

@@ rtl/core/rhcc_pkg.sv @@
// types, constants and the divider step shared by the colour classifier
`timescale 1ns / 1ps

package rhcc_pkg;

    localparam int unsigned CountW = 16;
    localparam int unsigned HueW   = 15;
    localparam int unsigned DivSteps = 16;

    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
    } pixel_t;

    typedef struct packed {
        logic [2:0]  hue_class;
        logic [14:0] hue_q6;
        logic [15:0] saturation_q16;
        logic [15:0] peak_level;
    } result_t;

    // which sector of the hue circle the item falls in
    typedef enum logic [1:0] {
        BASE_0   = 2'd0,
        BASE_120 = 2'd1,
        BASE_240 = 2'd2,
        BASE_360 = 2'd3
    } hue_base_t;

    // colour codes
    localparam logic [2:0] COLOUR_UNDEF      = 3'd0;
    localparam logic [2:0] COLOUR_RED        = 3'd1;
    localparam logic [2:0] COLOUR_ORANGE     = 3'd2;
    localparam logic [2:0] COLOUR_YELLOW     = 3'd3;
    localparam logic [2:0] COLOUR_GREEN      = 3'd4;
    localparam logic [2:0] COLOUR_LIGHT_BLUE = 3'd5;
    localparam logic [2:0] COLOUR_BLUE       = 3'd6;
    localparam logic [2:0] COLOUR_PINK       = 3'd7;

    // degrees in q6
    localparam logic [14:0] HUE_Q6_120 = 15'(120 * 64);
    localparam logic [14:0] HUE_Q6_240 = 15'(240 * 64);
    localparam logic [14:0] HUE_Q6_360 = 15'(360 * 64);
    localparam logic [14:0] HUE_Q6_MAX = 15'(360 * 64 - 1);

    // bin edges in q6
    localparam logic [14:0] EDGE_ORANGE     = 15'(10 * 64);
    localparam logic [14:0] EDGE_YELLOW     = 15'(30 * 64);
    localparam logic [14:0] EDGE_GREEN      = 15'(80 * 64);
    localparam logic [14:0] EDGE_LIGHT_BLUE = 15'(150 * 64);
    localparam logic [14:0] EDGE_BLUE       = 15'(215 * 64);
    localparam logic [14:0] EDGE_PINK       = 15'(270 * 64);
    localparam logic [14:0] EDGE_RED_HIGH   = 15'(350 * 64);

    localparam logic [15:0] SAT_MAX = 16'hFFFF;

    // classification held after the first stage
    typedef struct packed {
        logic [15:0] peak;
        logic [15:0] diff;
        logic [15:0] span;
        logic        neg;
        hue_base_t   base;
        logic        grey;
        logic        sat_full;
    } class_t;

    // state carried through the divider stages
    typedef struct packed {
        logic [15:0] hue_rem;
        logic [15:0] hue_low;
        logic [15:0] hue_quo;
        logic [15:0] sat_rem;
        logic [15:0] sat_quo;
        logic [15:0] peak;
        logic [15:0] diff;
        logic        neg;
        hue_base_t   base;
        logic        grey;
        logic        sat_full;
    } div_t;

    // one restoring step of both dividers: hue by diff, saturation by peak
    function automatic div_t div_step(input div_t s);
        div_t        o;
        logic [16:0] hue_sh;
        logic [16:0] sat_sh;
        o = s;
        hue_sh = {s.hue_rem, s.hue_low[15]};
        sat_sh = {s.sat_rem, 1'b0};
        o.hue_low = {s.hue_low[14:0], 1'b0};
        if (hue_sh >= {1'b0, s.diff})
        begin
            o.hue_rem = 16'(hue_sh - {1'b0, s.diff});
            o.hue_quo = {s.hue_quo[14:0], 1'b1};
        end
        else
        begin
            o.hue_rem = hue_sh[15:0];
            o.hue_quo = {s.hue_quo[14:0], 1'b0};
        end
        if (sat_sh >= {1'b0, s.peak})
        begin
            o.sat_rem = 16'(sat_sh - {1'b0, s.peak});
            o.sat_quo = {s.sat_quo[14:0], 1'b1};
        end
        else
        begin
            o.sat_rem = sat_sh[15:0];
            o.sat_quo = {s.sat_quo[14:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ rtl/core/rhcc_front.sv @@
// front stages: max/min search, sector pick, divider setup
`timescale 1ns / 1ps

module rhcc_front
    import rhcc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    input  pixel_t pixel,
    output logic   ready,
    input  logic   down_ready,
    output logic   valid,
    output div_t   data
);

    logic   cls_valid_reg;
    logic   cls_valid_next;
    class_t cls_reg;
    class_t cls_next;
    logic   cls_ready;

    logic   div_valid_reg;
    logic   div_valid_next;
    div_t   div_reg;
    div_t   div_next;

    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] mx;
    logic [15:0] mn;
    logic [15:0] p;
    logic [15:0] q;
    logic [27:0] scaled;

    assign r = pixel.red_count;
    assign g = pixel.green_count;
    assign b = pixel.blue_count;

    assign cls_ready = !div_valid_reg || down_ready;
    assign ready     = !cls_valid_reg || cls_ready;

    // stage one: extremes and sector
    always_comb
    begin
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        // blue wins ties over green, green over red
        if (b == mx)
        begin
            cls_next.base = BASE_240;
            p = r;
            q = g;
        end
        else if (g == mx)
        begin
            cls_next.base = BASE_120;
            p = b;
            q = r;
        end
        else if (g >= b)
        begin
            cls_next.base = BASE_0;
            p = g;
            q = b;
        end
        else
        begin
            cls_next.base = BASE_360;
            p = g;
            q = b;
        end
        cls_next.peak     = mx;
        cls_next.diff     = 16'(mx - mn);
        cls_next.neg      = (p < q);
        cls_next.span     = (p < q) ? 16'(q - p) : 16'(p - q);
        cls_next.grey     = (mx == mn);
        cls_next.sat_full = (mn == 16'd0);
    end

    // stage two: span * 3840 as shift and subtract, divider start values
    always_comb
    begin
        scaled = {cls_reg.span, 12'd0} - {4'd0, cls_reg.span, 8'd0};
        div_next.hue_rem  = {4'd0, scaled[27:16]};
        div_next.hue_low  = scaled[15:0];
        div_next.hue_quo  = 16'd0;
        div_next.sat_rem  = cls_reg.diff;
        div_next.sat_quo  = 16'd0;
        div_next.peak     = cls_reg.peak;
        div_next.diff     = cls_reg.diff;
        div_next.neg      = cls_reg.neg;
        div_next.base     = cls_reg.base;
        div_next.grey     = cls_reg.grey;
        div_next.sat_full = cls_reg.sat_full;
    end

    assign cls_valid_next = ready ? pixel_valid : cls_valid_reg;
    assign div_valid_next = cls_ready ? cls_valid_reg : div_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            cls_valid_reg <= cls_valid_next;
            div_valid_reg <= div_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && pixel_valid)
        begin
            cls_reg <= cls_next;
        end
        if (cls_ready && cls_valid_reg)
        begin
            div_reg <= div_next;
        end
    end

    assign valid = div_valid_reg;
    assign data  = div_reg;

endmodule

@@ rtl/core/rhcc_div_stage.sv @@
// one register stage of the hue and saturation dividers
`timescale 1ns / 1ps

module rhcc_div_stage
    import rhcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  div_t up_data,
    output logic ready,
    input  logic down_ready,
    output logic valid,
    output div_t data
);

    logic valid_reg;
    logic valid_next;
    div_t data_reg;
    div_t data_next;

    assign ready      = !valid_reg || down_ready;
    assign valid_next = ready ? up_valid : valid_reg;
    assign data_next  = div_step(up_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/core/rhcc_back.sv @@
// last stage: hue rounding and offset, binning, saturation clamp
`timescale 1ns / 1ps

module rhcc_back
    import rhcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  div_t    up_data,
    output logic    ready,
    input  logic    result_stall,
    output logic    result_valid,
    output result_t result
);

    logic        valid_reg;
    logic        valid_next;
    result_t     result_reg;
    result_t     result_next;
    logic [12:0] mag;
    logic [14:0] base_q6;
    logic [14:0] hue;

    assign ready      = !valid_reg || !result_stall;
    assign valid_next = ready ? up_valid : valid_reg;

    always_comb
    begin
        // ceiling for the sectors that subtract
        mag = {1'b0, up_data.hue_quo[11:0]}
            + {12'd0, up_data.neg && (up_data.hue_rem != 16'd0)};
        case (up_data.base)
            BASE_0:   base_q6 = 15'd0;
            BASE_120: base_q6 = HUE_Q6_120;
            BASE_240: base_q6 = HUE_Q6_240;
            BASE_360: base_q6 = HUE_Q6_360;
            default:  base_q6 = 15'd0;
        endcase
        hue = up_data.neg ? 15'(base_q6 - {2'd0, mag}) : 15'(base_q6 + {2'd0, mag});

        if (hue >= EDGE_RED_HIGH || hue < EDGE_ORANGE)
        begin
            result_next.hue_class = COLOUR_RED;
        end
        else if (hue < EDGE_YELLOW)
        begin
            result_next.hue_class = COLOUR_ORANGE;
        end
        else if (hue < EDGE_GREEN)
        begin
            result_next.hue_class = COLOUR_YELLOW;
        end
        else if (hue < EDGE_LIGHT_BLUE)
        begin
            result_next.hue_class = COLOUR_GREEN;
        end
        else if (hue < EDGE_BLUE)
        begin
            result_next.hue_class = COLOUR_LIGHT_BLUE;
        end
        else if (hue < EDGE_PINK)
        begin
            result_next.hue_class = COLOUR_BLUE;
        end
        else
        begin
            result_next.hue_class = COLOUR_PINK;
        end
        result_next.hue_q6         = hue;
        result_next.saturation_q16 = up_data.sat_full ? SAT_MAX : up_data.sat_quo;
        result_next.peak_level     = up_data.peak;
        if (up_data.grey)
        begin
            result_next.hue_class      = COLOUR_UNDEF;
            result_next.hue_q6         = 15'd0;
            result_next.saturation_q16 = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/core/rgb_hue_colour_classifier.sv @@
// top level of the rgb hue colour classifier pipeline
`timescale 1ns / 1ps

// classifies one raw red/green/blue count triple into a colour code, hue in
// degrees times 64, saturation in 1/65536 and the peak channel count. the
// block is a 19-stage pipeline: two front stages (max/min and sector pick,
// then span times 3840 by shift and subtract), sixteen restoring divider
// stages that each resolve one quotient bit of both the hue division
// (span*3840/diff) and the saturation division (diff*65536/peak), and one
// output stage that applies the hue ceiling and sector offset, bins the hue
// and clamps the saturation. one item is accepted every cycle while the pipe
// is not stalled; each item passes the two front registers, the divider
// stages and the output register, and result_valid rises as it is loaded.
// stages hold no state between items, so empty stages close up behind a
// stalled result and pixel_stall only rises once the whole pipe is full.
// grey items (all channels equal) give code 0, hue 0 and saturation 0, and
// peak_level always carries the largest raw count.
module rgb_hue_colour_classifier
    import rhcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_stall,
    input  pixel_t  pixel,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // chain of divider stages; index 0 is the front output
    logic div_valid [0:DivSteps];
    div_t div_data  [0:DivSteps];
    // ready of each divider stage, last slot is the output stage
    logic div_ready [1:DivSteps+1];
    logic front_ready;

    rhcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .ready       (front_ready),
        .down_ready  (div_ready[1]),
        .valid       (div_valid[0]),
        .data        (div_data[0])
    );

    assign pixel_stall = !front_ready;

    // one quotient bit per stage
    for (genvar k = 1; k <= DivSteps; k++)
    begin : g_div
        rhcc_div_stage u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (div_valid[k-1]),
            .up_data    (div_data[k-1]),
            .ready      (div_ready[k]),
            .down_ready (div_ready[k+1]),
            .valid      (div_valid[k]),
            .data       (div_data[k])
        );
    end

    // output register doubles as the finishing stage
    rhcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (div_valid[DivSteps]),
        .up_data      (div_data[DivSteps]),
        .ready        (div_ready[DivSteps+1]),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ rtl/core/rhcc_checker.sv @@
// port-level checks for the colour classifier, bound to the top level
`timescale 1ns / 1ps

`include "rgb_hue_colour_classifier_defines.svh"

module rhcc_checker
    import rhcc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a held result keeps its value
    `RHCC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))

    // undefined colour carries no hue or saturation
    `RHCC_ASSERT_NOW(a_grey_zero, result_valid && (result.hue_class == COLOUR_UNDEF), (result.hue_q6 == 15'd0) && (result.saturation_q16 == 16'd0))

    // hue stays below a full turn
    `RHCC_ASSERT_NOW(a_hue_range, result_valid, result.hue_q6 <= HUE_Q6_MAX)

    // a defined colour needs a nonzero peak and saturation
    `RHCC_ASSERT_NOW(a_colour_peak, result_valid && (result.hue_class != COLOUR_UNDEF), (result.peak_level != 16'd0) && (result.saturation_q16 != 16'd0))

endmodule

bind rgb_hue_colour_classifier rhcc_checker u_rhcc_checker (.*);

@@ test/tb_rgb_hue_colour_classifier.sv @@
// self-checking testbench for the rgb hue colour classifier pipeline
`timescale 1ns / 1ps

module tb_rgb_hue_colour_classifier;
    import rhcc_pkg::*;

    // one sixth of the hue circle in q6
    localparam int unsigned SIXTY_DEG_Q6 = 60 * 64;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned TAIL_CYCLES  = 40;

    // pending item: pixel plus driving hints
    typedef struct packed {
        pixel_t px;
        logic   drain;   // hold off until every expected result has come
        logic   calm;    // no idling on either side around this item
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    pixel_valid = 1'b0;
    logic    pixel_stall;
    pixel_t  pixel = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    pending_t    pixel_queue[$];
    result_t     expected_results[$];
    pending_t    next_item;
    result_t     want;
    logic        calm_now = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned mismatch_count = 0;

    rgb_hue_colour_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // base + 60*(p - q)/d in q6, floor of the exact value
    function automatic int unsigned sector_hue(input int unsigned base, input int unsigned p,
                                               input int unsigned q, input int unsigned d);
        if (p >= q)
            return base + (SIXTY_DEG_Q6 * (p - q)) / d;
        return base - (SIXTY_DEG_Q6 * (q - p) + d - 1) / d;
    endfunction

    function automatic result_t predict_colour(input pixel_t px);
        result_t         res;
        int unsigned     r;
        int unsigned     g;
        int unsigned     b;
        int unsigned     mx;
        int unsigned     mn;
        int unsigned     d;
        int unsigned     hue;
        longint unsigned sat;
        r = px.red_count;
        g = px.green_count;
        b = px.blue_count;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res = '0;
        res.peak_level = mx[15:0];
        // grey or black: everything but the peak is zero
        if (mx == mn)
            return res;
        d = mx - mn;
        // blue wins ties over green, green over red
        if (b == mx)
            hue = sector_hue(HUE_Q6_240, r, g, d);
        else if (g == mx)
            hue = sector_hue(HUE_Q6_120, b, r, d);
        else if (g >= b)
            hue = sector_hue(0, g, b, d);
        else
            hue = sector_hue(HUE_Q6_360, g, b, d);
        sat = d;
        sat = (sat << 16) / mx;
        if (sat > 65535)
            sat = 65535;
        if (hue >= EDGE_RED_HIGH || hue < EDGE_ORANGE)
            res.hue_class = COLOUR_RED;
        else if (hue < EDGE_YELLOW)
            res.hue_class = COLOUR_ORANGE;
        else if (hue < EDGE_GREEN)
            res.hue_class = COLOUR_YELLOW;
        else if (hue < EDGE_LIGHT_BLUE)
            res.hue_class = COLOUR_GREEN;
        else if (hue < EDGE_BLUE)
            res.hue_class = COLOUR_LIGHT_BLUE;
        else if (hue < EDGE_PINK)
            res.hue_class = COLOUR_BLUE;
        else
            res.hue_class = COLOUR_PINK;
        res.hue_q6 = hue[14:0];
        res.saturation_q16 = sat[15:0];
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_pixel(input int unsigned r, input int unsigned g, input int unsigned b,
                             input logic drain, input logic calm);
        pending_t item;
        item.px.red_count   = r[15:0];
        item.px.green_count = g[15:0];
        item.px.blue_count  = b[15:0];
        item.drain = drain;
        item.calm  = calm;
        pixel_queue.push_back(item);
    endtask

    // one channel value from the extremes or anywhere in range
    function automatic int unsigned edge_or_any();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 65535;
        return $urandom_range(0, 65535);
    endfunction

    task automatic add_random_pixel(input logic drain, input logic calm);
        int unsigned kind;
        int unsigned top;
        int unsigned v [3];
        int unsigned k;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            for (k = 0; k < 3; k++)
                v[k] = $urandom_range(0, 65535);
        end
        else if (kind < 55)
        begin
            // near grey: tiny spans, large and small levels
            top = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
            for (k = 0; k < 3; k++)
            begin
                v[k] = top + $urandom_range(0, 3);
                if (v[k] > 65535)
                    v[k] = 65535;
            end
        end
        else if (kind < 70)
        begin
            // two or three channels share the maximum
            top = $urandom_range(1, 65535);
            for (k = 0; k < 3; k++)
                v[k] = top;
            k = $urandom_range(0, 3);
            if (k < 3)
                v[k] = $urandom_range(0, top - 1);
        end
        else if (kind < 85)
        begin
            for (k = 0; k < 3; k++)
                v[k] = $urandom_range(0, 15);
        end
        else
        begin
            for (k = 0; k < 3; k++)
                v[k] = edge_or_any();
        end
        add_pixel(v[0], v[1], v[2], drain, calm);
    endtask

    // sender: pops pending items, holds them until accepted, idles between
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                expected_results.push_back(predict_colour(pixel));
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    pixel_valid <= 1'b0;
                end
                else if (pixel_queue.size() == 0)
                    pixel_valid <= 1'b0;
                else if (pixel_queue[0].drain && expected_results.size() != 0)
                    pixel_valid <= 1'b0;
                else
                begin
                    next_item = pixel_queue.pop_front();
                    pixel <= next_item.px;
                    pixel_valid <= 1'b1;
                    calm_now <= next_item.calm;
                    send_gap = next_item.calm ? 0 : idle_length();
                end
            end
        end
    end

    // receiver: checks each accepted result and stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $realtime, result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.hue_class != want.hue_class)
                    begin
                        $display("%0t: hue_class expected %0d actual %0d", $realtime,
                                 want.hue_class, result.hue_class);
                        mismatch_count++;
                    end
                    if (result.hue_q6 != want.hue_q6)
                    begin
                        $display("%0t: hue_q6 expected %0d actual %0d", $realtime,
                                 want.hue_q6, result.hue_q6);
                        mismatch_count++;
                    end
                    if (result.saturation_q16 != want.saturation_q16)
                    begin
                        $display("%0t: saturation_q16 expected %0d actual %0d", $realtime,
                                 want.saturation_q16, result.saturation_q16);
                        mismatch_count++;
                    end
                    if (result.peak_level != want.peak_level)
                    begin
                        $display("%0t: peak_level expected %0d actual %0d", $realtime,
                                 want.peak_level, result.peak_level);
                        mismatch_count++;
                    end
                end
            end
            if (calm_now)
            begin
                stall_left = 0;
                result_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 75)
                result_stall <= 1'b0;
            else
            begin
                stall_left = idle_length();
                result_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned i;
        // grey and black, including the extremes
        add_pixel(0, 0, 0, 1'b0, 1'b0);
        add_pixel(65535, 65535, 65535, 1'b0, 1'b0);
        add_pixel(1234, 1234, 1234, 1'b0, 1'b0);
        // pure primaries, zero minimum saturates
        add_pixel(65535, 0, 0, 1'b0, 1'b0);
        add_pixel(0, 65535, 0, 1'b0, 1'b0);
        add_pixel(0, 0, 65535, 1'b0, 1'b0);
        add_pixel(1, 0, 0, 1'b0, 1'b0);
        // ties for the maximum
        add_pixel(65535, 65535, 0, 1'b0, 1'b0);
        add_pixel(0, 65535, 65535, 1'b0, 1'b0);
        add_pixel(65535, 0, 65535, 1'b0, 1'b0);
        // bin edges, on and just off
        add_pixel(600, 100, 0, 1'b0, 1'b0);
        add_pixel(600, 99, 0, 1'b0, 1'b0);
        add_pixel(600, 300, 0, 1'b0, 1'b0);
        add_pixel(400, 600, 0, 1'b0, 1'b0);
        add_pixel(0, 600, 300, 1'b0, 1'b0);
        add_pixel(0, 500, 1200, 1'b0, 1'b0);
        add_pixel(300, 0, 600, 1'b0, 1'b0);
        add_pixel(600, 0, 100, 1'b0, 1'b0);
        add_pixel(600, 0, 101, 1'b0, 1'b0);
        // rounding of negative hue offsets, top of the hue range
        add_pixel(7, 0, 1, 1'b0, 1'b0);
        add_pixel(65535, 0, 1, 1'b0, 1'b0);
        // smallest spans
        add_pixel(65535, 65534, 65534, 1'b0, 1'b0);
        add_pixel(2, 1, 1, 1'b0, 1'b0);
        for (i = 0; i < RANDOM_ITEMS; i++)
            add_random_pixel(i == 0 || i % 550 == 275, i % 400 < 50);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (pixel_queue.size() != 0 || pixel_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rgb_hue_colour_classifier: clean");
        else
            $display("tb_rgb_hue_colour_classifier: errors");
        $finish;
    end

    // watchdog well past the slowest legal run
    initial
    begin
        #20000000;
        $display("tb_rgb_hue_colour_classifier: errors");
        $finish;
    end

endmodule

@@ rgb_hue_colour_classifier.f @@
+incdir+rtl/core
rtl/core/rhcc_pkg.sv
rtl/core/rhcc_front.sv
rtl/core/rhcc_div_stage.sv
rtl/core/rhcc_back.sv
rtl/core/rgb_hue_colour_classifier.sv
rtl/core/rhcc_checker.sv
test/tb_rgb_hue_colour_classifier.sv
